### hdl/dbg_pkg.sv
// Shared types, constants and helper functions of the detection box grouping unit.
// No dependencies; every other file of the block imports this package.
package dbg_pkg;

   localparam int MAX_BOXES  = 64;
   localparam int COORD_BITS = 12;
   localparam int IDX_W      = $clog2(MAX_BOXES);
   localparam int CNT_W      = IDX_W + 1;
   localparam int SUM_W      = COORD_BITS + IDX_W;
   localparam int EDGE_W     = COORD_BITS + 1;
   localparam int THR_W      = 7;
   localparam int WGT_W      = 16;
   localparam int TOL_W      = WGT_W + EDGE_W;
   localparam int SHIFT      = WGT_W + 1;
   localparam int CMP_W      = EDGE_W + SHIFT;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT    = 1'd1;

   localparam logic [THR_W-1:0] THR_RESET = 7'd2;
   localparam logic [WGT_W-1:0] WGT_RESET = 16'd13107;

   typedef struct packed {
      logic [COORD_BITS-1:0] left;
      logic [COORD_BITS-1:0] top;
      logic [COORD_BITS-1:0] width;
      logic [COORD_BITS-1:0] height;
   } box_type;

   typedef struct packed {
      logic             valid;
      logic [CNT_W-1:0] count;
      logic             ovf;
   } job_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      box_type          box;
   } wr_type;

   typedef struct packed {
      logic take;
      logic done;
   } eng_status_type;

   typedef struct packed {
      box_type box;
      logic    none_found;
      logic    capacity_exceeded;
      logic    final_item;
   } rsp_type;

   // a lies within b, edges included
   function automatic logic inside_box(box_type a, box_type b);
      logic [EDGE_W-1:0] ar, ab, br, bb;
      ar = EDGE_W'(a.left) + EDGE_W'(a.width);
      ab = EDGE_W'(a.top) + EDGE_W'(a.height);
      br = EDGE_W'(b.left) + EDGE_W'(b.width);
      bb = EDGE_W'(b.top) + EDGE_W'(b.height);
      return (a.left >= b.left) && (a.top >= b.top) && (ar <= br) && (ab <= bb);
   endfunction

   function automatic logic [EDGE_W-1:0] abs_diff(logic [EDGE_W-1:0] a,
                                                  logic [EDGE_W-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

endpackage

### hdl/dbg_front.sv
// Input side: accepts requests, writes rectangles into the engine's box store,
// and hands a finished set to the engine through a one-deep job queue. Uses dbg_pkg.
module dbg_front import dbg_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_push,
   output logic           req_full,
   input  box_type        req_box,
   input  logic           req_set_end,
   input  eng_status_type eng_stat,
   output job_type        job,
   output wr_type         box_wr
);

   logic [CNT_W-1:0] cnt_ff, cnt_in, cnt_nx;
   logic             ovf_ff, ovf_in, ovf_nx;
   logic             hold_ff, hold_in;
   job_type          job_ff, job_in;
   logic             acc, room;

   assign acc  = req_push & ~hold_ff;
   assign room = cnt_ff < CNT_W'(MAX_BOXES);

   always_comb begin
      cnt_nx      = room ? cnt_ff + 1'b1 : cnt_ff;
      ovf_nx      = ovf_ff | ~room;
      cnt_in      = cnt_ff;
      ovf_in      = ovf_ff;
      hold_in     = hold_ff;
      job_in      = job_ff;
      box_wr.en   = acc & room;
      box_wr.addr = cnt_ff[IDX_W-1:0];
      box_wr.box  = req_box;
      if (acc) begin
         if (req_set_end) begin
            job_in  = '{valid: 1'b1, count: cnt_nx, ovf: ovf_nx};
            cnt_in  = '0;
            ovf_in  = 1'b0;
            hold_in = 1'b1;
         end else begin
            cnt_in = cnt_nx;
            ovf_in = ovf_nx;
         end
      end
      if (eng_stat.take) begin
         job_in.valid = 1'b0;
      end
      // hold off new requests until the engine has released the box store
      if (eng_stat.done) begin
         hold_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         ovf_ff  <= 1'b0;
         hold_ff <= 1'b0;
         job_ff  <= '0;
      end else begin
         cnt_ff  <= cnt_in;
         ovf_ff  <= ovf_in;
         hold_ff <= hold_in;
         job_ff  <= job_in;
      end
   end

   assign req_full = hold_ff;
   assign job      = job_ff;

endmodule

### hdl/dbg_div.sv
// Four-lane restoring divider with a shared divisor, one quotient bit per cycle.
// Used by dbg_engine for the group averages. Uses dbg_pkg.
module dbg_div import dbg_pkg::*; (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [3:0][SUM_W-1:0]            dividend,
   input  logic [CNT_W-1:0]                 divisor,
   output logic                             done,
   output logic [3:0][COORD_BITS-1:0]       quot
);

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [STEP_W-1:0]           step_ff, step_in;
   logic [CNT_W-1:0]            dv_ff, dv_in;
   logic [3:0][CNT_W-1:0]       rem_ff, rem_in;
   logic [3:0][SUM_W-1:0]       q_ff, q_in;
   logic [CNT_W:0]              trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dv_in   = dv_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      trial   = '0;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(SUM_W);
         dv_in   = divisor;
         rem_in  = '0;
         q_in    = dividend;
      end else if (busy_ff) begin
         for (int l = 0; l < 4; l++) begin
            trial = {rem_ff[l], q_ff[l][SUM_W-1]};
            if (trial >= {1'b0, dv_ff}) begin
               rem_in[l] = CNT_W'(trial - {1'b0, dv_ff});
               q_in[l]   = {q_ff[l][SUM_W-2:0], 1'b1};
            end else begin
               rem_in[l] = trial[CNT_W-1:0];
               q_in[l]   = {q_ff[l][SUM_W-2:0], 1'b0};
            end
         end
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      dv_ff  <= dv_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   always_comb begin
      for (int l = 0; l < 4; l++) begin
         quot[l] = q_ff[l][COORD_BITS-1:0];
      end
   end

endmodule

### hdl/dbg_rsp_fifo.sv
// Small result queue between the engine and the rsp_ ports.
// Uses dbg_pkg.
module dbg_rsp_fifo import dbg_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_item,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output rsp_type head
);

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);

   rsp_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [PTR_W:0]     cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign full    = cnt_ff == (PTR_W+1)'(DEPTH);
   assign empty   = cnt_ff == '0;
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   always_comb begin
      wp_in  = do_push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = do_pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wp_ff] <= push_item;
      end
   end

   assign head = mem_ff[rp_ff];

endmodule

### hdl/dbg_engine.sv
// Back part: similarity pass with union-find, group sums, averages,
// containment pass and result generation. Uses dbg_pkg and dbg_div.
module dbg_engine import dbg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  wr_type           box_wr,
   input  job_type          job,
   input  logic [THR_W-1:0] thr,
   input  logic [WGT_W-1:0] wgt,
   input  logic             out_full,
   output logic             out_push,
   output rsp_type          out_item,
   output eng_status_type   stat
);

   localparam logic [4:0] ST_IDLE   = 5'd0;
   localparam logic [4:0] ST_INIT   = 5'd1;
   localparam logic [4:0] ST_LDI    = 5'd2;
   localparam logic [4:0] ST_CAPI   = 5'd3;
   localparam logic [4:0] ST_RDJ    = 5'd4;
   localparam logic [4:0] ST_DIF    = 5'd5;
   localparam logic [4:0] ST_TOL    = 5'd6;
   localparam logic [4:0] ST_CMP    = 5'd7;
   localparam logic [4:0] ST_FRD    = 5'd8;
   localparam logic [4:0] ST_FCHK   = 5'd9;
   localparam logic [4:0] ST_UNI    = 5'd10;
   localparam logic [4:0] ST_RSTART = 5'd11;
   localparam logic [4:0] ST_ARD    = 5'd12;
   localparam logic [4:0] ST_AWR    = 5'd13;
   localparam logic [4:0] ST_VRD    = 5'd14;
   localparam logic [4:0] ST_VCHK   = 5'd15;
   localparam logic [4:0] ST_VDIV   = 5'd16;
   localparam logic [4:0] ST_CIRD   = 5'd17;
   localparam logic [4:0] ST_CICAP  = 5'd18;
   localparam logic [4:0] ST_CJRD   = 5'd19;
   localparam logic [4:0] ST_CJCHK  = 5'd20;
   localparam logic [4:0] ST_CIEND  = 5'd21;
   localparam logic [4:0] ST_FIN    = 5'd22;

   localparam logic [1:0] FM_I = 2'd0;
   localparam logic [1:0] FM_J = 2'd1;
   localparam logic [1:0] FM_R = 2'd2;

   // storage
   box_type              box_mem [MAX_BOXES];
   logic [IDX_W-1:0]     par_mem [MAX_BOXES];
   logic [CNT_W-1:0]     cnt_mem [MAX_BOXES];
   logic [2*SUM_W-1:0]   sh_mem  [MAX_BOXES];
   logic [2*SUM_W-1:0]   sv_mem  [MAX_BOXES];
   box_type              avg_mem [MAX_BOXES];

   box_type              box_rd_ff, avg_rd_ff;
   logic [IDX_W-1:0]     par_rd_ff;
   logic [CNT_W-1:0]     cnt_rd_ff;
   logic [2*SUM_W-1:0]   sh_rd_ff, sv_rd_ff;

   logic                 box_re;
   logic [IDX_W-1:0]     box_ra, par_ra, sum_ra, avg_ra;
   logic                 par_we, sum_we, avg_we;
   logic [IDX_W-1:0]     par_wa, sum_wa, avg_wa, par_wd;
   logic [CNT_W-1:0]     cnt_wd;
   logic [2*SUM_W-1:0]   sh_wd, sv_wd;
   box_type              avg_wd;

   // control and datapath registers
   logic [4:0]             st_ff, st_in;
   logic [1:0]             fm_ff, fm_in;
   logic [CNT_W-1:0]       n_ff, n_in, i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic                   ovf_ff, ovf_in;
   logic [IDX_W-1:0]       x_ff, x_in, ri_ff, ri_in;
   box_type                bi_ff, bi_in, ai_ff, ai_in, pend_ff, pend_in;
   logic [3:0][EDGE_W-1:0] d_ff, d_in;
   logic [EDGE_W-1:0]      msum_ff, msum_in;
   logic [TOL_W-1:0]       tol_ff, tol_in;
   logic                   drop_ff, drop_in, pv_ff, pv_in;

   logic [THR_W-1:0]       thr_eff;
   logic                   sim;
   logic                   div_start, div_done;
   logic [3:0][SUM_W-1:0]  div_num;
   logic [3:0][COORD_BITS-1:0] div_q;

   assign thr_eff = (thr == '0) ? THR_W'(1) : thr;

   assign div_num[0] = sh_rd_ff[SUM_W-1:0];
   assign div_num[1] = sv_rd_ff[SUM_W-1:0];
   assign div_num[2] = sh_rd_ff[2*SUM_W-1:SUM_W];
   assign div_num[3] = sv_rd_ff[2*SUM_W-1:SUM_W];

   dbg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (cnt_rd_ff),
      .done     (div_done),
      .quot     (div_q)
   );

   always_comb begin
      sim = 1'b1;
      for (int q = 0; q < 4; q++) begin
         if ({d_ff[q], SHIFT'(0)} > CMP_W'(tol_ff)) begin
            sim = 1'b0;
         end
      end
   end

   always_comb begin
      st_in     = st_ff;
      fm_in     = fm_ff;
      n_in      = n_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      ovf_in    = ovf_ff;
      x_in      = x_ff;
      ri_in     = ri_ff;
      bi_in     = bi_ff;
      ai_in     = ai_ff;
      pend_in   = pend_ff;
      d_in      = d_ff;
      msum_in   = msum_ff;
      tol_in    = tol_ff;
      drop_in   = drop_ff;
      pv_in     = pv_ff;
      box_re    = 1'b0;
      box_ra    = '0;
      par_ra    = '0;
      sum_ra    = '0;
      avg_ra    = '0;
      par_we    = 1'b0;
      par_wa    = '0;
      par_wd    = '0;
      sum_we    = 1'b0;
      sum_wa    = '0;
      cnt_wd    = '0;
      sh_wd     = '0;
      sv_wd     = '0;
      avg_we    = 1'b0;
      avg_wa    = k_ff[IDX_W-1:0];
      avg_wd    = '0;
      div_start = 1'b0;
      out_push  = 1'b0;
      out_item  = '0;
      stat      = '0;

      unique case (st_ff)
         ST_IDLE: begin
            pv_in = 1'b0;
            if (job.valid) begin
               stat.take = 1'b1;
               n_in      = job.count;
               ovf_in    = job.ovf;
               i_in      = '0;
               st_in     = ST_INIT;
            end
         end
         ST_INIT: begin
            if (i_ff < n_ff) begin
               par_we = 1'b1;
               par_wa = i_ff[IDX_W-1:0];
               par_wd = i_ff[IDX_W-1:0];
               sum_we = 1'b1;
               sum_wa = i_ff[IDX_W-1:0];
               i_in   = i_ff + 1'b1;
            end else begin
               i_in  = '0;
               st_in = ST_LDI;
            end
         end
         ST_LDI: begin
            if (i_ff >= n_ff) begin
               i_in  = '0;
               st_in = ST_RSTART;
            end else begin
               box_re = 1'b1;
               box_ra = i_ff[IDX_W-1:0];
               st_in  = ST_CAPI;
            end
         end
         ST_CAPI: begin
            bi_in = box_rd_ff;
            j_in  = i_ff + 1'b1;
            st_in = ST_RDJ;
         end
         ST_RDJ: begin
            if (j_ff >= n_ff) begin
               i_in  = i_ff + 1'b1;
               st_in = ST_LDI;
            end else begin
               box_re = 1'b1;
               box_ra = j_ff[IDX_W-1:0];
               st_in  = ST_DIF;
            end
         end
         ST_DIF: begin
            d_in[0] = abs_diff(EDGE_W'(bi_ff.left), EDGE_W'(box_rd_ff.left));
            d_in[1] = abs_diff(EDGE_W'(bi_ff.top), EDGE_W'(box_rd_ff.top));
            d_in[2] = abs_diff(EDGE_W'(bi_ff.left) + EDGE_W'(bi_ff.width),
                               EDGE_W'(box_rd_ff.left) + EDGE_W'(box_rd_ff.width));
            d_in[3] = abs_diff(EDGE_W'(bi_ff.top) + EDGE_W'(bi_ff.height),
                               EDGE_W'(box_rd_ff.top) + EDGE_W'(box_rd_ff.height));
            msum_in = EDGE_W'((bi_ff.width < box_rd_ff.width) ? bi_ff.width
                                                               : box_rd_ff.width)
                    + EDGE_W'((bi_ff.height < box_rd_ff.height) ? bi_ff.height
                                                                 : box_rd_ff.height);
            st_in = ST_TOL;
         end
         ST_TOL: begin
            tol_in = TOL_W'(wgt) * TOL_W'(msum_ff);
            st_in  = ST_CMP;
         end
         ST_CMP: begin
            if (sim) begin
               x_in  = i_ff[IDX_W-1:0];
               fm_in = FM_I;
               st_in = ST_FRD;
            end else begin
               j_in  = j_ff + 1'b1;
               st_in = ST_RDJ;
            end
         end
         ST_FRD: begin
            par_ra = x_ff;
            st_in  = ST_FCHK;
         end
         ST_FCHK: begin
            if (par_rd_ff == x_ff) begin
               if (fm_ff == FM_I) begin
                  ri_in = x_ff;
                  x_in  = j_ff[IDX_W-1:0];
                  fm_in = FM_J;
                  st_in = ST_FRD;
               end else if (fm_ff == FM_J) begin
                  st_in = ST_UNI;
               end else begin
                  st_in = ST_ARD;
               end
            end else begin
               x_in  = par_rd_ff;
               st_in = ST_FRD;
            end
         end
         ST_UNI: begin
            // attach the root of box j under the root of box i
            if (ri_ff != x_ff) begin
               par_we = 1'b1;
               par_wa = x_ff;
               par_wd = ri_ff;
            end
            j_in  = j_ff + 1'b1;
            st_in = ST_RDJ;
         end
         ST_RSTART: begin
            if (i_ff >= n_ff) begin
               i_in  = '0;
               k_in  = '0;
               st_in = ST_VRD;
            end else begin
               box_re = 1'b1;
               box_ra = i_ff[IDX_W-1:0];
               x_in   = i_ff[IDX_W-1:0];
               fm_in  = FM_R;
               st_in  = ST_FRD;
            end
         end
         ST_ARD: begin
            sum_ra = x_ff;
            st_in  = ST_AWR;
         end
         ST_AWR: begin
            sum_we = 1'b1;
            sum_wa = x_ff;
            cnt_wd = cnt_rd_ff + 1'b1;
            sh_wd  = {sh_rd_ff[2*SUM_W-1:SUM_W] + SUM_W'(box_rd_ff.width),
                      sh_rd_ff[SUM_W-1:0] + SUM_W'(box_rd_ff.left)};
            sv_wd  = {sv_rd_ff[2*SUM_W-1:SUM_W] + SUM_W'(box_rd_ff.height),
                      sv_rd_ff[SUM_W-1:0] + SUM_W'(box_rd_ff.top)};
            i_in   = i_ff + 1'b1;
            st_in  = ST_RSTART;
         end
         ST_VRD: begin
            if (i_ff >= n_ff) begin
               i_in  = '0;
               st_in = ST_CIRD;
            end else begin
               par_ra = i_ff[IDX_W-1:0];
               sum_ra = i_ff[IDX_W-1:0];
               st_in  = ST_VCHK;
            end
         end
         ST_VCHK: begin
            if ((par_rd_ff == i_ff[IDX_W-1:0]) && (32'(cnt_rd_ff) >= 32'(thr_eff))) begin
               div_start = 1'b1;
               st_in     = ST_VDIV;
            end else begin
               i_in  = i_ff + 1'b1;
               st_in = ST_VRD;
            end
         end
         ST_VDIV: begin
            if (div_done) begin
               avg_we = 1'b1;
               avg_wd = '{left: div_q[0], top: div_q[1],
                          width: div_q[2], height: div_q[3]};
               k_in   = k_ff + 1'b1;
               i_in   = i_ff + 1'b1;
               st_in  = ST_VRD;
            end
         end
         ST_CIRD: begin
            if (i_ff >= k_ff) begin
               st_in = ST_FIN;
            end else begin
               avg_ra = i_ff[IDX_W-1:0];
               st_in  = ST_CICAP;
            end
         end
         ST_CICAP: begin
            ai_in   = avg_rd_ff;
            j_in    = '0;
            drop_in = 1'b0;
            st_in   = ST_CJRD;
         end
         ST_CJRD: begin
            if (j_ff >= k_ff) begin
               st_in = ST_CIEND;
            end else if (j_ff == i_ff) begin
               j_in = j_ff + 1'b1;
            end else begin
               avg_ra = j_ff[IDX_W-1:0];
               st_in  = ST_CJCHK;
            end
         end
         ST_CJCHK: begin
            if (inside_box(ai_ff, avg_rd_ff)) begin
               drop_in = 1'b1;
               st_in   = ST_CIEND;
            end else begin
               j_in  = j_ff + 1'b1;
               st_in = ST_CJRD;
            end
         end
         ST_CIEND: begin
            // keep one survivor back so the last one can carry final_item
            if (drop_ff) begin
               i_in  = i_ff + 1'b1;
               st_in = ST_CIRD;
            end else if (!(pv_ff && out_full)) begin
               out_push = pv_ff;
               out_item = '{box: pend_ff, none_found: 1'b0,
                            capacity_exceeded: ovf_ff, final_item: 1'b0};
               pend_in  = ai_ff;
               pv_in    = 1'b1;
               i_in     = i_ff + 1'b1;
               st_in    = ST_CIRD;
            end
         end
         ST_FIN: begin
            if (!out_full) begin
               out_push = 1'b1;
               out_item = '{box: pv_ff ? pend_ff : '0, none_found: ~pv_ff,
                            capacity_exceeded: ovf_ff, final_item: 1'b1};
               stat.done = 1'b1;
               pv_in     = 1'b0;
               st_in     = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         pv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         pv_ff <= pv_in;
      end
      fm_ff   <= fm_in;
      n_ff    <= n_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      k_ff    <= k_in;
      ovf_ff  <= ovf_in;
      x_ff    <= x_in;
      ri_ff   <= ri_in;
      bi_ff   <= bi_in;
      ai_ff   <= ai_in;
      pend_ff <= pend_in;
      d_ff    <= d_in;
      msum_ff <= msum_in;
      tol_ff  <= tol_in;
      drop_ff <= drop_in;
   end

   // memories
   always_ff @(posedge clock) begin
      if (box_wr.en) begin
         box_mem[box_wr.addr] <= box_wr.box;
      end
      if (box_re) begin
         box_rd_ff <= box_mem[box_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (par_we) begin
         par_mem[par_wa] <= par_wd;
      end
      par_rd_ff <= par_mem[par_ra];
   end

   always_ff @(posedge clock) begin
      if (sum_we) begin
         cnt_mem[sum_wa] <= cnt_wd;
         sh_mem[sum_wa]  <= sh_wd;
         sv_mem[sum_wa]  <= sv_wd;
      end
      cnt_rd_ff <= cnt_mem[sum_ra];
      sh_rd_ff  <= sh_mem[sum_ra];
      sv_rd_ff  <= sv_mem[sum_ra];
   end

   always_ff @(posedge clock) begin
      if (avg_we) begin
         avg_mem[avg_wa] <= avg_wd;
      end
      avg_rd_ff <= avg_mem[avg_ra];
   end

endmodule

### hdl/detection_box_grouping_unit.sv
// Detection box grouping unit, top level. Loads one rectangle per cycle while req_full
// is low; the set_end request starts processing, during which req_full stays high
// (one set at a time). Processing clears the union-find state, runs the similarity pass
// with union-find steps and joins, gathers the group sums, averages each surviving group
// with the bit-serial divider, and runs the containment pass over the groups.
// Synchronous active-high reset clears control state, restores threshold 2 and weight 13107.
module detection_box_grouping_unit import dbg_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [COORD_BITS-1:0]  req_box_left,
   input  logic [COORD_BITS-1:0]  req_box_top,
   input  logic [COORD_BITS-1:0]  req_box_width,
   input  logic [COORD_BITS-1:0]  req_box_height,
   input  logic                   req_set_end,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [COORD_BITS-1:0]  rsp_merged_left,
   output logic [COORD_BITS-1:0]  rsp_merged_top,
   output logic [COORD_BITS-1:0]  rsp_merged_width,
   output logic [COORD_BITS-1:0]  rsp_merged_height,
   output logic                   rsp_none_found,
   output logic                   rsp_capacity_exceeded,
   output logic                   rsp_final_item,
   input  logic                   csr_wr_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [THR_W-1:0] thr_ff, thr_in;
   logic [WGT_W-1:0] wgt_ff, wgt_in;
   box_type          req_box;
   job_type          job;
   wr_type           box_wr;
   eng_status_type   eng_stat;
   logic             out_full, out_push;
   rsp_type          out_item, head;

   always_comb begin
      thr_in = thr_ff;
      wgt_in = wgt_ff;
      if (csr_wr_en && (csr_index == CSR_THRESHOLD)) begin
         thr_in = csr_wdata[THR_W-1:0];
      end
      if (csr_wr_en && (csr_index == CSR_WEIGHT)) begin
         wgt_in = csr_wdata[WGT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
         wgt_ff <= WGT_RESET;
      end else begin
         thr_ff <= thr_in;
         wgt_ff <= wgt_in;
      end
   end

   assign req_box = '{left: req_box_left, top: req_box_top,
                      width: req_box_width, height: req_box_height};

   dbg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_box     (req_box),
      .req_set_end (req_set_end),
      .eng_stat    (eng_stat),
      .job         (job),
      .box_wr      (box_wr)
   );

   dbg_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .box_wr   (box_wr),
      .job      (job),
      .thr      (thr_ff),
      .wgt      (wgt_ff),
      .out_full (out_full),
      .out_push (out_push),
      .out_item (out_item),
      .stat     (eng_stat)
   );

   dbg_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_item (out_item),
      .full      (out_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .head      (head)
   );

   assign rsp_merged_left       = head.box.left;
   assign rsp_merged_top        = head.box.top;
   assign rsp_merged_width      = head.box.width;
   assign rsp_merged_height     = head.box.height;
   assign rsp_none_found        = head.none_found;
   assign rsp_capacity_exceeded = head.capacity_exceeded;
   assign rsp_final_item        = head.final_item;

endmodule

### hdl/dbg_checker.sv
// Port-level checks of the detection box grouping unit, bound to the top level.
// Uses dbg_pkg for widths.
module dbg_checker import dbg_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_push,
   input logic                  req_full,
   input logic                  req_set_end,
   input logic                  rsp_empty,
   input logic                  rsp_pop,
   input logic [COORD_BITS-1:0] rsp_merged_left,
   input logic [COORD_BITS-1:0] rsp_merged_top,
   input logic [COORD_BITS-1:0] rsp_merged_width,
   input logic [COORD_BITS-1:0] rsp_merged_height,
   input logic                  rsp_none_found,
   input logic                  rsp_final_item
);

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_merged_left))
      else $error("waiting result changed");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_none_found |-> rsp_merged_left == '0 && rsp_merged_top == '0
         && rsp_merged_width == '0 && rsp_merged_height == '0)
      else $error("none_found result with nonzero rectangle");

   a_none_final: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_none_found |-> rsp_final_item)
      else $error("none_found result not marked final");

   a_end_stalls: assert property (@(posedge clock) disable iff (reset)
      req_push && !req_full && req_set_end |=> req_full)
      else $error("request taken while set is processed");

endmodule

bind detection_box_grouping_unit dbg_checker u_chk (.*);
